@@ design/snac_pkg.sv @@
// Package: shared widths, constants and payload types of the surface element unit.
`timescale 1ns / 1ps
package snac_pkg;

  // Vertex and arithmetic widths
  localparam int CoordW   = 16;
  localparam int NormFrac = 15;
  localparam int NormW    = NormFrac + 1;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int CrossW   = ProdW + 1;
  localparam int MagW     = CrossW - 1;
  localparam int HalfW    = MagW / 2;
  localparam int SqW      = 2 * MagW;
  localparam int SumW     = SqW + 2;
  localparam int RootW    = SumW / 2;
  localparam int RemW     = RootW + 2;
  localparam int DivRemW  = RootW + 1;
  localparam int QuotW    = NormFrac + 2;
  localparam int DivSteps = NormFrac + 1;
  localparam int AreaW    = 33;
  localparam int ThrW     = 34;

  // Center arithmetic: quad sum, and biased triangle numerator 2*sum + 3
  localparam int CSumW     = CoordW + 2;
  localparam int TriNumW   = CoordW + 4;
  localparam int TriOffset = 6 * (1 << (CoordW - 1)) + 3;
  localparam int TriShift  = TriNumW + 3;
  localparam int TriRecipW = TriNumW + 1;
  localparam int TriRecip  = ((1 << TriShift) + 5) / 6;

  localparam logic [NormW-1:0] NormLim = NormW'((1 << NormFrac) - 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MESH_KIND = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic            mesh_kind;
    logic [ThrW-1:0] degenerate_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
    logic signed [CoordW-1:0] v3_x;
    logic signed [CoordW-1:0] v3_y;
    logic signed [CoordW-1:0] v3_z;
    logic signed [CoordW-1:0] v4_x;
    logic signed [CoordW-1:0] v4_y;
    logic signed [CoordW-1:0] v4_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic [AreaW-1:0]         area;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic                     degenerate;
  } out_item_t;

  // Data that rides along with the length computation
  typedef struct packed {
    logic signed [CrossW-1:0] nx;
    logic signed [CrossW-1:0] ny;
    logic signed [CrossW-1:0] nz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } side_t;

endpackage

@@ design/snac_in_if.sv @@
// Interface: input channel carrying one surface element per beat.
`timescale 1ns / 1ps
interface snac_in_if import snac_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/snac_out_if.sv @@
// Interface: output channel carrying one normal, area and center per beat.
`timescale 1ns / 1ps
interface snac_out_if import snac_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/snac_cfg_if.sv @@
// Interface: configuration write channel.
`timescale 1ns / 1ps
interface snac_cfg_if import snac_pkg::*;;
  logic            valid;
  logic            ready;
  cfg_reg_e        index;
  logic [ThrW-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ design/snac_front.sv @@
// Front end: edge vectors, cross product, squared length and element center.
`timescale 1ns / 1ps
module snac_front import snac_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  in_item_t        item_i,
  input  logic            mesh_kind_i,
  output logic            valid_o,
  output logic [SumW-1:0] sum_o,
  output side_t           side_o
);

  localparam int NStg = 6;

  logic [NStg-1:0] vld_q;

  logic signed [CoordW-1:0] v1 [3];
  logic signed [CoordW-1:0] v2 [3];
  logic signed [CoordW-1:0] v3 [3];
  logic signed [CoordW-1:0] v4 [3];

  // stage 1 signals
  logic signed [DiffW-1:0]   a_d [3];
  logic signed [DiffW-1:0]   b_d [3];
  logic signed [CSumW-1:0]   cq_d [3];
  logic [TriNumW-1:0]        ct_d [3];
  logic signed [DiffW-1:0]   a_q [3];
  logic signed [DiffW-1:0]   b_q [3];
  logic signed [CSumW-1:0]   cq_q [3];
  logic [TriNumW-1:0]        ct_q [3];
  logic                      tri_q;

  // stage 2 signals
  logic signed [ProdW-1:0]   p_d [6];
  logic signed [ProdW-1:0]   p_q [6];
  logic signed [CoordW-1:0]  c_d [3];
  logic signed [CoordW-1:0]  c_q [3];

  // stage 3 signals
  logic signed [CrossW-1:0]  n_d [3];
  logic [MagW-1:0]           m_d [3];
  logic [MagW-1:0]           m_q [3];
  side_t                     side3_d;
  side_t                     side3_q;

  // stage 4 to 6 signals
  logic [2*HalfW-1:0]        hh_d [3];
  logic [2*HalfW-1:0]        hl_d [3];
  logic [2*HalfW-1:0]        ll_d [3];
  logic [2*HalfW-1:0]        hh_q [3];
  logic [2*HalfW-1:0]        hl_q [3];
  logic [2*HalfW-1:0]        ll_q [3];
  side_t                     side4_q;
  logic [SqW-1:0]            sq_d [3];
  logic [SqW-1:0]            sq_q [3];
  side_t                     side5_q;
  logic [SumW-1:0]           sum_d;
  logic [SumW-1:0]           sum_q;
  side_t                     side6_q;

  always_comb begin
    v1[0] = item_i.v1_x; v1[1] = item_i.v1_y; v1[2] = item_i.v1_z;
    v2[0] = item_i.v2_x; v2[1] = item_i.v2_y; v2[2] = item_i.v2_z;
    v3[0] = item_i.v3_x; v3[1] = item_i.v3_y; v3[2] = item_i.v3_z;
    v4[0] = item_i.v4_x; v4[1] = item_i.v4_y; v4[2] = item_i.v4_z;
  end

  // stage 1: edge vectors and center sums
  always_comb begin
    logic signed [CSumW-1:0]   s3;
    logic signed [TriNumW:0]   tn;
    for (int k = 0; k < 3; k++) begin
      if (mesh_kind_i) begin
        a_d[k] = DiffW'(v2[k]) - DiffW'(v1[k]);
        b_d[k] = DiffW'(v3[k]) - DiffW'(v1[k]);
      end else begin
        a_d[k] = DiffW'(v3[k]) - DiffW'(v1[k]);
        b_d[k] = DiffW'(v4[k]) - DiffW'(v2[k]);
      end
      s3      = CSumW'(v1[k]) + CSumW'(v2[k]) + CSumW'(v3[k]);
      cq_d[k] = s3 + CSumW'(v4[k]) + CSumW'(2);
      tn      = ((TriNumW + 1)'(s3) <<< 1) + (TriNumW + 1)'(TriOffset);
      ct_d[k] = tn[TriNumW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= b_d;
      cq_q  <= cq_d;
      ct_q  <= ct_d;
      tri_q <= mesh_kind_i;
    end
  end

  // stage 2: six partial cross products, center by shift or reciprocal
  always_comb begin
    logic [TriNumW+TriRecipW-1:0] cm;
    logic [CoordW-1:0]            tq;
    p_d[0] = a_q[1] * b_q[2];
    p_d[1] = a_q[2] * b_q[1];
    p_d[2] = a_q[2] * b_q[0];
    p_d[3] = a_q[0] * b_q[2];
    p_d[4] = a_q[0] * b_q[1];
    p_d[5] = a_q[1] * b_q[0];
    for (int k = 0; k < 3; k++) begin
      cm = (TriNumW + TriRecipW)'(ct_q[k]) * (TriNumW + TriRecipW)'(TriRecip);
      tq = cm[TriShift +: CoordW];
      if (tri_q) begin
        c_d[k] = {~tq[CoordW-1], tq[CoordW-2:0]};
      end else begin
        c_d[k] = cq_q[k][CSumW-1:2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
      c_q <= c_d;
    end
  end

  // stage 3: cross product components and magnitudes
  always_comb begin
    n_d[0] = CrossW'(p_q[0]) - CrossW'(p_q[1]);
    n_d[1] = CrossW'(p_q[2]) - CrossW'(p_q[3]);
    n_d[2] = CrossW'(p_q[4]) - CrossW'(p_q[5]);
    for (int k = 0; k < 3; k++) begin
      m_d[k] = n_d[k][CrossW-1] ? MagW'(-n_d[k]) : MagW'(n_d[k]);
    end
    side3_d = '{nx: n_d[0], ny: n_d[1], nz: n_d[2], cx: c_q[0], cy: c_q[1], cz: c_q[2]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= m_d;
      side3_q <= side3_d;
    end
  end

  // stage 4: squares split into half-width partial products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_d[k] = (2*HalfW)'(m_q[k][MagW-1:HalfW]) * (2*HalfW)'(m_q[k][MagW-1:HalfW]);
      hl_d[k] = (2*HalfW)'(m_q[k][MagW-1:HalfW]) * (2*HalfW)'(m_q[k][HalfW-1:0]);
      ll_d[k] = (2*HalfW)'(m_q[k][HalfW-1:0]) * (2*HalfW)'(m_q[k][HalfW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q    <= hh_d;
      hl_q    <= hl_d;
      ll_q    <= ll_d;
      side4_q <= side3_q;
    end
  end

  // stage 5: assemble each square
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = (SqW'(hh_q[k]) << (2*HalfW)) + (SqW'(hl_q[k]) << (HalfW + 1))
              + SqW'(ll_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= sq_d;
      side5_q <= side4_q;
    end
  end

  // stage 6: squared length
  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      side6_q <= side5_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NStg-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign sum_o   = sum_q;
  assign side_o  = side6_q;

endmodule

@@ design/snac_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module snac_sqrt import snac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SumW-1:0]  rad_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output side_t            side_o
);

  logic [RootW:0]   vld;
  logic [RemW-1:0]  rem  [RootW+1];
  logic [RootW-1:0] root [RootW+1];
  logic [SumW-1:0]  rad  [RootW+1];
  side_t            side [RootW+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             take;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;
    logic [RemW-1:0]  rem_q;
    logic [RootW-1:0] root_q;
    logic [SumW-1:0]  rad_q;
    side_t            side_q;
    logic             vld_q;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem[i][RemW-3:0], rad[i][SumW-1:SumW-2]};
      trial  = {root[i], 2'b01};
      take   = rem_sh >= trial;
      rem_d  = take ? rem_sh - trial : rem_sh;
      root_d = {root[i][RootW-2:0], take};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= {rad[i][SumW-3:0], 2'b00};
        side_q <= side[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[i];
      end
    end

    assign rem[i+1]  = rem_q;
    assign root[i+1] = root_q;
    assign rad[i+1]  = rad_q;
    assign side[i+1] = side_q;
    assign vld[i+1]  = vld_q;
  end

  assign valid_o = vld[RootW];
  assign root_o  = root[RootW];
  assign side_o  = side[RootW];

endmodule

@@ design/snac_div.sv @@
// Normalizing divider: three restoring-division lanes, rounding and output register.
`timescale 1ns / 1ps
module snac_div import snac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RootW-1:0] len_i,
  input  side_t            side_i,
  input  logic [ThrW-1:0]  thr_i,
  output logic             valid_o,
  output out_item_t        item_o
);

  typedef struct packed {
    logic [RootW-1:0]         len;
    logic                     degen;
    logic [2:0]               neg;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } div_ctl_t;

  logic [DivSteps:0]   vld;
  logic [DivRemW-1:0]  r   [DivSteps+1][3];
  logic [QuotW-1:0]    q   [DivSteps+1][3];
  div_ctl_t            ctl [DivSteps+1];

  // first stage: magnitudes, degenerate test, integer quotient bit
  logic [MagW-1:0]     m0 [3];
  logic signed [CrossW-1:0] n0 [3];
  logic [DivRemW-1:0]  r0_d [3];
  logic [QuotW-1:0]    q0_d [3];
  div_ctl_t            ctl0_d;
  logic [DivRemW-1:0]  r0_q [3];
  logic [QuotW-1:0]    q0_q [3];
  div_ctl_t            ctl0_q;
  logic                vld0_q;

  always_comb begin
    n0[0] = side_i.nx;
    n0[1] = side_i.ny;
    n0[2] = side_i.nz;
    for (int k = 0; k < 3; k++) begin
      m0[k] = n0[k][CrossW-1] ? MagW'(-n0[k]) : MagW'(n0[k]);
      if (DivRemW'(m0[k]) >= DivRemW'(len_i)) begin
        q0_d[k] = QuotW'(1);
        r0_d[k] = DivRemW'(m0[k]) - DivRemW'(len_i);
      end else begin
        q0_d[k] = '0;
        r0_d[k] = DivRemW'(m0[k]);
      end
    end
    ctl0_d.len   = len_i;
    ctl0_d.degen = (len_i < RootW'(thr_i)) || (len_i == '0);
    ctl0_d.neg   = {n0[2][CrossW-1], n0[1][CrossW-1], n0[0][CrossW-1]};
    ctl0_d.cx    = side_i.cx;
    ctl0_d.cy    = side_i.cy;
    ctl0_d.cz    = side_i.cz;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r0_q   <= r0_d;
      q0_q   <= q0_d;
      ctl0_q <= ctl0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  assign vld[0] = vld0_q;
  assign r[0]   = r0_q;
  assign q[0]   = q0_q;
  assign ctl[0] = ctl0_q;

  // fraction stages: one quotient bit per lane per stage
  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [DivRemW-1:0] r_d [3];
    logic [QuotW-1:0]   q_d [3];
    logic [DivRemW-1:0] r_q [3];
    logic [QuotW-1:0]   q_q [3];
    div_ctl_t           ctl_q;
    logic               vld_q;

    always_comb begin
      logic [DivRemW-1:0] rs;
      logic               ge;
      for (int k = 0; k < 3; k++) begin
        rs     = {r[j][k][DivRemW-2:0], 1'b0};
        ge     = rs >= DivRemW'(ctl[j].len);
        r_d[k] = ge ? rs - DivRemW'(ctl[j].len) : rs;
        q_d[k] = {q[j][k][QuotW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q   <= r_d;
        q_q   <= q_d;
        ctl_q <= ctl[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[j];
      end
    end

    assign r[j+1]   = r_q;
    assign q[j+1]   = q_q;
    assign ctl[j+1] = ctl_q;
    assign vld[j+1] = vld_q;
  end

  // last stage: round half away, saturate, apply sign; this is the output register
  logic signed [NormW-1:0] nrm_d [3];
  out_item_t               item_d;
  out_item_t               item_q;
  logic                    vld_out_q;

  always_comb begin
    logic [QuotW:0]   qr;
    logic [QuotW-1:0] qh;
    logic [NormW-1:0] mg;
    for (int k = 0; k < 3; k++) begin
      qr = (QuotW + 1)'(q[DivSteps][k]) + (QuotW + 1)'(1);
      qh = qr[QuotW:1];
      mg = (qh > QuotW'(NormLim)) ? NormLim : qh[NormW-1:0];
      if (ctl[DivSteps].degen) begin
        nrm_d[k] = '0;
      end else if (ctl[DivSteps].neg[k]) begin
        nrm_d[k] = -mg;
      end else begin
        nrm_d[k] = mg;
      end
    end
    item_d.normal_x   = nrm_d[0];
    item_d.normal_y   = nrm_d[1];
    item_d.normal_z   = nrm_d[2];
    item_d.area       = ctl[DivSteps].len[AreaW:1];
    item_d.center_x   = ctl[DivSteps].cx;
    item_d.center_y   = ctl[DivSteps].cy;
    item_d.center_z   = ctl[DivSteps].cz;
    item_d.degenerate = ctl[DivSteps].degen;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld[DivSteps];
    end
  end

  assign valid_o = vld_out_q;
  assign item_o  = item_q;

endmodule

@@ design/surface_normal_area_center.sv @@
// Top level: surface element unit normal, area and center, fully pipelined.
// Pipeline: 6 front stages, 35 square-root stages at one root bit each, 17 divider
//   stages, then the rounding/output register.
// Throughput: one element per cycle; the whole pipe holds while the output waits.
// Reset: clears all valid bits; mesh_kind resets to quad, threshold to 1.
`timescale 1ns / 1ps
module surface_normal_area_center import snac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  snac_in_if.sink    in_i,
  snac_out_if.source out_o,
  snac_cfg_if.sink   cfg_i
);

  cfg_t             cfg_q;
  logic             en;
  logic             fr_valid;
  logic [SumW-1:0]  fr_sum;
  side_t            fr_side;
  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  side_t            sq_side;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mesh_kind            <= 1'b0;
      cfg_q.degenerate_threshold <= ThrW'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MESH_KIND: cfg_q.mesh_kind            <= cfg_i.wdata[0];
        REG_THRESHOLD: cfg_q.degenerate_threshold <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished beat is held at the output
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  snac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_i.valid),
    .item_i      (in_i.data),
    .mesh_kind_i (cfg_q.mesh_kind),
    .valid_o     (fr_valid),
    .sum_o       (fr_sum),
    .side_o      (fr_side)
  );

  snac_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_sum),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  snac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .len_i   (sq_root),
    .side_i  (sq_side),
    .thr_i   (cfg_q.degenerate_threshold),
    .valid_o (out_o.valid),
    .item_o  (out_o.data)
  );

endmodule

@@ design/snac_checker.sv @@
// Checker: port-level assertions for the surface element unit, bound to the top level.
`timescale 1ns / 1ps
module snac_checker import snac_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // a stalled output beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // with no beat held at the output the input side must take beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output");

  // degenerate elements carry a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.degenerate |->
      out_data_i.normal_x == '0 && out_data_i.normal_y == '0 &&
      out_data_i.normal_z == '0)
    else $error("degenerate element with nonzero normal");

  // normals saturate symmetrically
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.normal_x != {1'b1, {(NormW-1){1'b0}}} &&
      out_data_i.normal_y != {1'b1, {(NormW-1){1'b0}}} &&
      out_data_i.normal_z != {1'b1, {(NormW-1){1'b0}}})
    else $error("normal component outside the symmetric range");

  // a ready output never holds the pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("pipeline froze with the output ready");

endmodule

bind surface_normal_area_center snac_checker u_snac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
